FILE: design/mrrc_pkg.sv
// ----------------------------------------------------------------------------
// mrrc_pkg
// Shared types, codes and the crc-16/modbus byte update for the modbus rtu
// reply receiver and checker
// ----------------------------------------------------------------------------
`default_nettype none

package mrrc_pkg;

    // input item function codes
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_BYTE  = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;
    localparam logic [1:0] FUNC_ABORT = 2'd3;

    // end status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TIMEOUT   = 3'd1;
    localparam logic [2:0] ST_CRC       = 3'd2;
    localparam logic [2:0] ST_CODE      = 3'd3;
    localparam logic [2:0] ST_REGISTER  = 3'd4;
    localparam logic [2:0] ST_UNKNOWN   = 3'd5;

    // configuration register indexes
    localparam logic CFG_FIRST_BYTE_TIMEOUT = 1'b0;
    localparam logic CFG_REPLY_TIMEOUT      = 1'b1;

    localparam logic [7:0] FIRST_BYTE_TIMEOUT_RST = 8'd10;
    localparam logic [7:0] REPLY_TIMEOUT_RST      = 8'd100;

    // modbus function codes that get a full check
    localparam logic [7:0] MB_WRITE_MULTI = 8'h10;
    localparam logic [7:0] MB_READ_INPUT  = 8'h04;

    localparam logic [9:0] WRITE_MULTI_LEN = 10'd8;
    localparam logic [9:0] READ_OVERHEAD   = 10'd5;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // result queue
    localparam int          OQ_DEPTH = 4;
    localparam int          OQ_AW    = $clog2(OQ_DEPTH);
    localparam int          OQ_CW    = $clog2(OQ_DEPTH + 1);
    localparam logic [OQ_CW-1:0] OQ_ROOM_FOR_TWO = OQ_CW'(OQ_DEPTH - 2);

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] cmd_function_code;
        logic [7:0] cmd_addr_low;
        logic [7:0] cmd_quantity_low;
        logic [7:0] rx_byte;
    } in_t;

    typedef struct packed {
        logic       is_end;
        logic [7:0] reply_byte;
        logic [2:0] status;
        logic [9:0] reply_length;
    } out_t;

    // up to two results pushed per transaction
    typedef struct packed {
        logic first_vld;
        logic second_vld;
        out_t first;
        out_t second;
    } push_t;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: design/modbus_reply_receiver_checker_unit.sv
// ----------------------------------------------------------------------------
// modbus_reply_receiver_checker_unit
// Modbus rtu master reply receiver: echoes reply bytes, keeps crc-16/modbus,
// checks the finished reply and reports timeouts
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    mrrc_pkg::in_t  (func, cmd fields, rx_byte)
//  m_        out        m_valid/m_ready    mrrc_pkg::out_t (is_end, byte, status, length)
//  cfg_      in         cfg_we             cfg_index, cfg_wdata (no read-back)
//
//  one transaction per cycle sustained while the queue has room; an accepted item is held in the
//  input register, then the crc byte update and checks run on it as it leaves that register
//  a completing byte pushes two results (echo, then end) into a 4-entry queue
//  the input stage advances while the queue holds at most two results
//  synchronous active-low reset; no clearing pass, timeouts return to 10 / 100
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_reply_receiver_checker_unit (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    // input transactions
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire mrrc_pkg::in_t   s_data,
    // result transactions
    output logic                 m_valid,
    input  wire logic            m_ready,
    output mrrc_pkg::out_t       m_data,
    // configuration writes
    input  wire logic            cfg_we,
    input  wire logic            cfg_index,
    input  wire logic [7:0]      cfg_wdata
);
    import mrrc_pkg::*;

    // input register
    logic  in_vld_reg;
    in_t   in_data_reg;

    logic  room;
    logic  fire;
    push_t push;

    // the held item is processed once the queue can take both of its results
    assign fire    = in_vld_reg && room;
    // refill the input register in the same cycle it drains
    assign s_ready = !in_vld_reg || room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // transaction state, crc, capture and checks
    mrrc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .item      (in_data_reg),
        .push      (push)
    );

    // result queue decouples the two sides
    mrrc_out_queue u_out_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

FILE: design/mrrc_check.sv
// ----------------------------------------------------------------------------
// mrrc_check
// Reply check: crc residue, then function code, then register or byte count
// ----------------------------------------------------------------------------
`default_nettype none

module mrrc_check (
    input  wire logic [15:0]      crc,
    input  wire logic [7:0]       sent_code,
    input  wire logic [7:0]       sent_addr_low,
    input  wire logic [7:0]       sent_quantity_low,
    input  wire logic [3:0][7:0]  captured,
    output logic [2:0]            status
);
    import mrrc_pkg::*;

    always_comb begin
        if (crc != 16'h0000) begin
            status = ST_CRC;
        end else if (sent_code == MB_WRITE_MULTI) begin
            if (captured[0] != MB_WRITE_MULTI) begin
                status = ST_CODE;
            end else if (captured[2] != sent_addr_low || captured[3] != sent_quantity_low) begin
                status = ST_REGISTER;
            end else begin
                status = ST_OK;
            end
        end else if (sent_code == MB_READ_INPUT) begin
            if (captured[0] != MB_READ_INPUT) begin
                status = ST_CODE;
            end else if ({sent_quantity_low, 1'b0} != {1'b0, captured[1]}) begin
                status = ST_REGISTER;
            end else begin
                status = ST_OK;
            end
        end else begin
            status = ST_UNKNOWN;
        end
    end

endmodule

`default_nettype wire

FILE: design/mrrc_ctrl.sv
// ----------------------------------------------------------------------------
// mrrc_ctrl
// Transaction state, crc, byte capture, timeouts and result generation
// ----------------------------------------------------------------------------
`default_nettype none

module mrrc_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_we,
    input  wire logic           cfg_index,
    input  wire logic [7:0]     cfg_wdata,
    input  wire logic           fire,
    input  wire mrrc_pkg::in_t  item,
    output mrrc_pkg::push_t     push
);
    import mrrc_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_RECV = 2'd2
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [7:0]      tick_reg, tick_next;
    logic [9:0]      bcnt_reg, bcnt_next;
    logic [9:0]      exp_reg, exp_next;
    logic [15:0]     crc_reg, crc_next;
    logic [7:0]      code_reg, code_next;
    logic [7:0]      addr_reg, addr_next;
    logic [7:0]      qty_reg, qty_next;
    logic [3:0][7:0] cap_reg, cap_next;
    logic [7:0]      fbt_reg, rto_reg;

    logic [15:0]     crc_byte;
    logic [3:0][7:0] cap_byte;
    logic [9:0]      bcnt_inc;
    logic [7:0]      limit;
    logic [2:0]      chk_status;
    logic            busy;

    assign busy     = (phase_reg == PH_WAIT) || (phase_reg == PH_RECV);
    assign crc_byte = crc_update(crc_reg, item.rx_byte);
    assign bcnt_inc = bcnt_reg + 10'd1;
    assign limit    = (phase_reg == PH_WAIT) ? fbt_reg : rto_reg;

    always_comb begin
        cap_byte = cap_reg;
        case (bcnt_reg)
            10'd1:   cap_byte[0] = item.rx_byte;
            10'd2:   cap_byte[1] = item.rx_byte;
            10'd3:   cap_byte[2] = item.rx_byte;
            10'd5:   cap_byte[3] = item.rx_byte;
            default: cap_byte = cap_reg;
        endcase
    end

    mrrc_check u_check (
        .crc               (crc_byte),
        .sent_code         (code_reg),
        .sent_addr_low     (addr_reg),
        .sent_quantity_low (qty_reg),
        .captured          (cap_byte),
        .status            (chk_status)
    );

    always_comb begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bcnt_next  = bcnt_reg;
        exp_next   = exp_reg;
        crc_next   = crc_reg;
        code_next  = code_reg;
        addr_next  = addr_reg;
        qty_next   = qty_reg;
        cap_next   = cap_reg;
        push       = '0;
        if (fire) begin
            unique case (item.func)
                FUNC_START: begin
                    code_next  = item.cmd_function_code;
                    addr_next  = item.cmd_addr_low;
                    qty_next   = item.cmd_quantity_low;
                    exp_next   = (item.cmd_function_code == MB_WRITE_MULTI) ? WRITE_MULTI_LEN :
                                 ({1'b0, item.cmd_quantity_low, 1'b0} + READ_OVERHEAD);
                    bcnt_next  = '0;
                    tick_next  = '0;
                    crc_next   = CRC_INIT;
                    phase_next = PH_WAIT;
                end
                FUNC_BYTE: begin
                    if (busy) begin
                        if (phase_reg == PH_WAIT) begin
                            tick_next  = '0;
                            phase_next = PH_RECV;
                        end
                        push.first_vld        = 1'b1;
                        push.first.reply_byte = item.rx_byte;
                        crc_next  = crc_byte;
                        cap_next  = cap_byte;
                        bcnt_next = bcnt_inc;
                        if (bcnt_inc == exp_reg) begin
                            push.second_vld          = 1'b1;
                            push.second.is_end       = 1'b1;
                            push.second.status       = chk_status;
                            push.second.reply_length = bcnt_inc;
                            phase_next = PH_IDLE;
                        end
                    end
                end
                FUNC_TICK: begin
                    if (busy) begin
                        if (tick_reg < limit) begin
                            tick_next = tick_reg + 8'd1;
                        end else begin
                            push.first_vld          = 1'b1;
                            push.first.is_end       = 1'b1;
                            push.first.status       = ST_TIMEOUT;
                            push.first.reply_length = bcnt_reg;
                            tick_next  = '0;
                            phase_next = PH_IDLE;
                        end
                    end
                end
                FUNC_ABORT: begin
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                    bcnt_next  = '0;
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            bcnt_reg  <= '0;
            exp_reg   <= '0;
            crc_reg   <= CRC_INIT;
            code_reg  <= '0;
            addr_reg  <= '0;
            qty_reg   <= '0;
            fbt_reg   <= FIRST_BYTE_TIMEOUT_RST;
            rto_reg   <= REPLY_TIMEOUT_RST;
        end else begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bcnt_reg  <= bcnt_next;
            exp_reg   <= exp_next;
            crc_reg   <= crc_next;
            code_reg  <= code_next;
            addr_reg  <= addr_next;
            qty_reg   <= qty_next;
            if (cfg_we) begin
                if (cfg_index == CFG_FIRST_BYTE_TIMEOUT) begin
                    fbt_reg <= cfg_wdata;
                end else begin
                    rto_reg <= cfg_wdata;
                end
            end
        end
    end

    // captured reply bytes are written before any check reads them
    always_ff @(posedge aclk) begin
        cap_reg <= cap_next;
    end

endmodule

`default_nettype wire

FILE: design/mrrc_out_queue.sv
// ----------------------------------------------------------------------------
// mrrc_out_queue
// Small result queue: up to two pushes and one pop per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module mrrc_out_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire mrrc_pkg::push_t  push,
    output logic                  room,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output mrrc_pkg::out_t        m_data
);
    import mrrc_pkg::*;

    out_t             entry_reg [OQ_DEPTH];
    logic [OQ_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [OQ_CW-1:0] cnt_reg;
    logic [OQ_AW-1:0] wr_second;
    logic             pop;

    assign m_valid   = (cnt_reg != '0);
    assign m_data    = entry_reg[rd_ptr_reg];
    assign pop       = m_valid && m_ready;
    assign room      = (cnt_reg <= OQ_ROOM_FOR_TWO);
    assign wr_second = wr_ptr_reg + OQ_AW'(push.first_vld);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + OQ_AW'(push.first_vld) + OQ_AW'(push.second_vld);
            rd_ptr_reg <= rd_ptr_reg + OQ_AW'(pop);
            cnt_reg    <= cnt_reg + OQ_CW'(push.first_vld) + OQ_CW'(push.second_vld)
                          - OQ_CW'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push.first_vld) begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.second_vld) begin
            entry_reg[wr_second] <= push.second;
        end
    end

endmodule

`default_nettype wire
